// ----- rtl/prm_pkg.sv -----
// shared constants, types and helpers for the press rate monitor
package prm_pkg;

  // stamp store geometry
  localparam int STAMP_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STAMP_DEPTH);
  localparam int CNT_W       = $clog2(STAMP_DEPTH + 1);

  // field widths
  localparam int TIME_W  = 32;
  localparam int PRES_W  = 12;
  localparam int IVL_W   = 16;
  localparam int WIN_W   = 16;
  localparam int COUNT_W = 9;
  localparam int RATE_W  = 21;

  // rate scaling: presses per minute times 100 with the window in ms
  localparam int                 SCALE_W    = 23;
  localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(6000000);
  localparam int                 PROD_W     = CNT_W + SCALE_W;
  localparam int                 STEP_W     = $clog2(PROD_W + 1);

  localparam logic [RATE_W-1:0]  RATE_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IVL_MIN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IVL_MAX   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 4'd3;

  localparam logic [PRES_W-1:0] THRESHOLD_RST = 12'd30;
  localparam logic [IVL_W-1:0]  IVL_MIN_RST   = 16'd100;
  localparam logic [IVL_W-1:0]  IVL_MAX_RST   = 16'd120;
  localparam logic [WIN_W-1:0]  WINDOW_RST    = 16'd5000;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // clamp a stamp count to the result field
  function automatic logic [COUNT_W-1:0] sat_count(input logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return (w > 32'(COUNT_MAX)) ? COUNT_MAX : w[COUNT_W-1:0];
  endfunction

  // clamp a quotient to the rate field
  function automatic logic [RATE_W-1:0] sat_rate(input logic [PROD_W-1:0] q);
    logic [63:0] w;
    w = 64'(q);
    return (w > 64'(RATE_MAX)) ? RATE_MAX : w[RATE_W-1:0];
  endfunction

endpackage

// ----- rtl/prm_if.sv -----
// handshake channel interfaces for samples, results and configuration
interface prm_sample_if import prm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] sample_time;
  logic [PRES_W-1:0] pressure;

  modport source (output valid, output sample_time, output pressure, input ready);
  modport sink (input valid, input sample_time, input pressure, output ready);
endinterface

interface prm_result_if import prm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               rhythm_alarm;
  logic               pressed;
  logic [COUNT_W-1:0] window_count;
  logic [RATE_W-1:0]  rate_centi;

  modport source (output valid, output rhythm_alarm, output pressed,
                  output window_count, output rate_centi, input ready);
  modport sink (input valid, input rhythm_alarm, input pressed,
                input window_count, input rate_centi, output ready);
endinterface

interface prm_cfg_if import prm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/prm_store.sv -----
// press timestamp memory, one write and one registered read port
module prm_store import prm_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [TIME_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [TIME_W-1:0] rd_data
);

  logic [TIME_W-1:0] mem [STAMP_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/prm_div.sv -----
// restoring divider, one quotient bit per cycle
module prm_div import prm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [PROD_W-1:0] dividend,
  input  logic [WIN_W-1:0]  divisor,
  output logic [PROD_W-1:0] quotient,
  output div_stat_t         stat
);

  logic [WIN_W-1:0]  rem;
  logic [PROD_W-1:0] quo;
  logic [WIN_W-1:0]  dsr;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [WIN_W:0]    rem_sh;
  logic              fits;
  logic [WIN_W:0]    rem_sub;

  assign rem_sh  = {rem, quo[PROD_W-1]};
  assign fits    = rem_sh >= {1'b0, dsr};
  assign rem_sub = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(PROD_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
      quo <= {quo[PROD_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- rtl/press_rate_monitor.sv -----
// press rate monitor top level: press detection, window scan and rate output
//
//   channel   dir   handshake       payload
//   samples   in    valid / ready   sample_time, pressure
//   results   out   valid / ready   rhythm_alarm, pressed, window_count, rate_centi
//   cfg       in    valid / ready   index, data (ready always high)
//
// a request runs from acceptance through the scan (one stamp read a cycle) and the divider
// (one quotient bit a cycle) to a valid result; the next sample is taken only once the block
// is back in idle
// rst is synchronous: registers to defaults, store empty, detector armed, memory kept
// a result waiting in the output register lets the next sample in; a stalled result
// holds the block only at its final step
module press_rate_monitor import prm_pkg::*; (
  input logic      clk,
  input logic      rst,
  prm_sample_if.sink   samples,
  prm_result_if.source results,
  prm_cfg_if.sink      cfg
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DIVGO = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [PRES_W-1:0] press_level;
  logic [IVL_W-1:0]  interval_min;
  logic [IVL_W-1:0]  interval_max;
  logic [WIN_W-1:0]  window_ms;

  // detector state
  logic [CNT_W-1:0]  stored_count;
  logic [ADDR_W-1:0] write_slot;
  logic              press_latched;
  logic [TIME_W-1:0] last_press_time;
  logic              alarm_level;

  // per request working registers
  logic [TIME_W-1:0] now;
  logic              pressed;
  logic [CNT_W-1:0]  rd_idx;
  logic              rd_pend;
  logic [CNT_W-1:0]  cnt;

  logic              accept;
  logic              below;
  logic              press;
  logic [TIME_W:0]   interval;
  logic              good;
  logic              issuing;
  logic [TIME_W-1:0] stamp;
  logic [TIME_W:0]   age;
  logic              in_window;
  logic [PROD_W-1:0] quotient;
  div_stat_t         div_stat;
  logic [PROD_W-1:0] product;
  logic              out_load;
  logic [RATE_W-1:0] rate;

  // config writes are always taken; the user must write only while the block is idle, it does not enforce this
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_level     <= THRESHOLD_RST;
      interval_min    <= IVL_MIN_RST;
      interval_max    <= IVL_MAX_RST;
      window_ms       <= WINDOW_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_THRESHOLD: press_level     <= cfg.data[PRES_W-1:0];
        REG_IVL_MIN:   interval_min    <= cfg.data[IVL_W-1:0];
        REG_IVL_MAX:   interval_max    <= cfg.data[IVL_W-1:0];
        REG_WINDOW:    window_ms       <= cfg.data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // press detection at the accepting edge
  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign below         = samples.pressure < press_level;
  assign press         = accept && !press_latched && below;

  // signed interval since the previous press; negative is never good
  assign interval = {1'b0, samples.sample_time} - {1'b0, last_press_time};
  assign good     = !interval[TIME_W]
                    && (interval[TIME_W-1:0] >= TIME_W'(interval_min))
                    && (interval[TIME_W-1:0] <= TIME_W'(interval_max));

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count    <= '0;
      write_slot      <= '0;
      press_latched   <= 1'b0;
      last_press_time <= '0;
      alarm_level     <= 1'b0;
    end else if (accept) begin
      if (press) begin
        // oldest slot is overwritten once the store is full
        write_slot      <= (write_slot == ADDR_W'(STAMP_DEPTH - 1)) ? '0
                           : write_slot + ADDR_W'(1);
        if (stored_count != CNT_W'(STAMP_DEPTH)) begin
          stored_count <= stored_count + CNT_W'(1);
        end
        last_press_time <= samples.sample_time;
        alarm_level     <= !good;
        press_latched   <= 1'b1;
      end
      if (!below) begin
        press_latched <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now     <= samples.sample_time;
      pressed <= below;
    end
  end

  // scan: one read issued per cycle, its data arrives in the cycle after
  assign issuing = (state == ST_SCAN) && (rd_idx != stored_count);

  prm_store u_store (
    .clk     (clk),
    .wr_en   (press),
    .wr_addr (write_slot),
    .wr_data (samples.sample_time),
    .rd_en   (issuing),
    .rd_addr (rd_idx[ADDR_W-1:0]),
    .rd_data (stamp)
  );

  // a stamp later than now counts as inside the window
  assign age       = {1'b0, now} - {1'b0, stamp};
  assign in_window = (stamp != '0)
                     && (age[TIME_W] || (age[TIME_W-1:0] <= TIME_W'(window_ms)));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= issuing;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx <= '0;
      cnt    <= '0;
    end else begin
      if (issuing) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (rd_pend && in_window) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // rate = cnt * 6000000 / window, the product goes straight into the divider
  assign product = PROD_W'(cnt) * PROD_W'(RATE_SCALE);

  prm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_DIVGO),
    .dividend (product),
    .divisor  (window_ms),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_comb begin
    if (cnt == '0) begin
      rate = '0;
    end else if (window_ms == '0) begin
      rate = RATE_MAX;
    end else begin
      rate = sat_rate(quotient);
    end
  end

  // output register, refilled once the previous result is taken
  assign out_load = (state == ST_OUT) && (!results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.rhythm_alarm <= alarm_level;
      results.pressed      <= pressed;
      results.window_count <= sat_count(cnt);
      results.rate_centi   <= rate;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_SCAN;
      ST_SCAN:  if (!issuing && !rd_pend) state_next = ST_DIVGO;
      ST_DIVGO: state_next = ST_DIV;
      ST_DIV:   if (div_stat.done) state_next = ST_OUT;
      ST_OUT:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(STAMP_DEPTH))
    else $error("stored count beyond store depth");

  a_press_grows: assert property (@(posedge clk) disable iff (rst)
    (press && stored_count != CNT_W'(STAMP_DEPTH))
      |=> (stored_count == $past(stored_count) + CNT_W'(1)))
    else $error("press did not grow the store");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (cnt <= stored_count))
    else $error("window count beyond stored stamps");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_SCAN) |-> !div_stat.busy)
    else $error("divider busy outside the rate step");

endmodule

// ----- bench/tb_press_rate_monitor.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the press rate monitor: directed table, random press trains
module tb_press_rate_monitor;
  import prm_pkg::*;

  // no sample, result or register write for this many cycles ends the run
  localparam int STALL_LIMIT = 6000;
  // long receiver hold-off that lets the block fill up and stall its input
  localparam int HOLD_CYCLES = 700;
  // quiet time after the last result, a bit more than one full-store request
  localparam int TAIL_CYCLES = 320;

  // register indexes that map to nothing, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'hF;

  localparam logic [PRES_W-1:0] PRES_TOP = '1;

  typedef struct packed {
    logic [TIME_W-1:0] sample_time;
    logic [PRES_W-1:0] pressure;
  } sample_t;

  typedef struct packed {
    logic               rhythm_alarm;
    logic               pressed;
    logic [COUNT_W-1:0] window_count;
    logic [RATE_W-1:0]  rate_centi;
  } reading_t;

  typedef enum logic [0:0] {ROW_CFG, ROW_SAMPLE} row_kind_t;

  // one line of the directed table: a register write or a sample, the
  // sample optionally with its result typed in
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    sample_t               smp;
    bit                    typed;
    reading_t              want;
  } plan_row_t;

  logic clk;
  logic rst;

  prm_sample_if samp_ch ();
  prm_result_if res_ch ();
  prm_cfg_if    cfg_ch ();

  press_rate_monitor DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (samp_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor: own copy of the registers and of the press state
  // ---------------------------------------------------------------------
  logic [PRES_W-1:0] cf_thr;
  logic [IVL_W-1:0]  cf_lo;
  logic [IVL_W-1:0]  cf_hi;
  logic [WIN_W-1:0]  cf_win;

  logic [TIME_W-1:0] st_stamps [STAMP_DEPTH];
  int unsigned       st_held;      // stamps written so far, caps at the depth
  int unsigned       st_slot;      // next slot to overwrite
  bit                st_latched;   // disarmed until pressure comes back up
  logic [TIME_W-1:0] st_last;      // time of the previous press
  bit                st_alarm;

  // readings still owed by the block, oldest first
  reading_t due_readings [$];

  int errors;

  // register write as the block sees it; narrow registers keep the low bits
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_THRESHOLD: cf_thr = data[PRES_W-1:0];
      REG_IVL_MIN:   cf_lo  = data[IVL_W-1:0];
      REG_IVL_MAX:   cf_hi  = data[IVL_W-1:0];
      REG_WINDOW:    cf_win = data[WIN_W-1:0];
      default: ;     // unmapped index, nothing changes
    endcase
  endfunction

  // advance the press state by one sample and work out its reading
  function automatic reading_t step_meter(input sample_t s);
    reading_t         r;
    bit               below;
    longint           gap;
    longint           age;
    int unsigned      hits;
    longint unsigned  quot;
    below = s.pressure < cf_thr;
    if (!st_latched && below) begin
      // intervals are signed, a step back in time is never good rhythm
      gap = longint'({32'h0, s.sample_time}) - longint'({32'h0, st_last});
      st_stamps[st_slot] = s.sample_time;
      st_slot = (st_slot + 1) % STAMP_DEPTH;
      if (st_held < STAMP_DEPTH)
        st_held++;
      st_last = s.sample_time;
      st_alarm = !(gap >= longint'({48'h0, cf_lo}) && gap <= longint'({48'h0, cf_hi}));
      st_latched = 1'b1;
    end
    if (!below)
      st_latched = 1'b0;

    // stamps of zero never count, stamps in the future always do
    hits = 0;
    for (int i = 0; i < st_held; i++) begin
      age = longint'({32'h0, s.sample_time}) - longint'({32'h0, st_stamps[i]});
      if (st_stamps[i] != '0 && age <= longint'({48'h0, cf_win}))
        hits++;
    end

    if (hits == 0)
      quot = 0;
    else if (cf_win == '0)
      quot = longint'(RATE_MAX);
    else begin
      quot = longint'(hits) * 64'd6000000 / longint'({48'h0, cf_win});
      if (quot > longint'(RATE_MAX))
        quot = longint'(RATE_MAX);
    end
    if (hits > int'(COUNT_MAX))
      hits = int'(COUNT_MAX);

    r.rhythm_alarm = st_alarm;
    r.pressed      = below;
    r.window_count = hits[COUNT_W-1:0];
    r.rate_centi   = quot[RATE_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // receiver: random ready, plus a long hold-off on request
  // ---------------------------------------------------------------------
  int  recv_idle_pct;
  int  send_idle_pct;
  bit  hold_toggle;
  bit  hold_seen;
  int  hold_left;

  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      // a new hold-off was asked for, count it down here
      hold_seen    <= hold_toggle;
      hold_left    <= HOLD_CYCLES;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // result checker: every accepted reading against the oldest one owed
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_readings.size() == 0) begin
        $error("reading with none owed: alarm %0d pressed %0d count %0d rate %0d",
               res_ch.rhythm_alarm, res_ch.pressed, res_ch.window_count,
               res_ch.rate_centi);
        errors++;
      end else begin
        exp_r = due_readings.pop_front();
        if (res_ch.rhythm_alarm !== exp_r.rhythm_alarm) begin
          $error("rhythm_alarm: expected %0d, got %0d", exp_r.rhythm_alarm,
                 res_ch.rhythm_alarm);
          errors++;
        end
        if (res_ch.pressed !== exp_r.pressed) begin
          $error("pressed: expected %0d, got %0d", exp_r.pressed, res_ch.pressed);
          errors++;
        end
        if (res_ch.window_count !== exp_r.window_count) begin
          $error("window_count: expected %0d, got %0d", exp_r.window_count,
                 res_ch.window_count);
          errors++;
        end
        if (res_ch.rate_centi !== exp_r.rate_centi) begin
          $error("rate_centi: expected %0d, got %0d", exp_r.rate_centi,
                 res_ch.rate_centi);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: counts cycles with no handshake on any channel
  // ---------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst || (samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("press_rate_monitor test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // drivers, all called right after a rising edge
  // ---------------------------------------------------------------------

  // offer one sample request, with random idle cycles ahead of it
  task automatic send_sample(input sample_t s, input bit typed, input reading_t want);
    reading_t calc;
    while ($urandom_range(99) < send_idle_pct) begin
      samp_ch.valid <= 1'b0;
      @(posedge clk);
    end
    samp_ch.valid       <= 1'b1;
    samp_ch.sample_time <= s.sample_time;
    samp_ch.pressure    <= s.pressure;
    do @(posedge clk); while (!samp_ch.ready);
    calc = step_meter(s);
    due_readings.push_back(typed ? want : calc);
  endtask

  // stop offering and let every owed reading come back
  task automatic drain_readings();
    samp_ch.valid <= 1'b0;
    while (due_readings.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------
  plan_row_t plan [$];

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    plan_row_t r;
    r.kind     = ROW_CFG;
    r.reg_idx  = idx;
    r.reg_data = data;
    r.smp      = '0;
    r.typed    = 1'b0;
    r.want     = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_smp(input logic [TIME_W-1:0] t, input logic [PRES_W-1:0] p);
    plan_row_t r;
    r.kind     = ROW_SAMPLE;
    r.reg_idx  = '0;
    r.reg_data = '0;
    r.smp      = '{sample_time: t, pressure: p};
    r.typed    = 1'b0;
    r.want     = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_chk(input logic [TIME_W-1:0] t, input logic [PRES_W-1:0] p,
                                  input bit alarm, input bit prs,
                                  input int unsigned cnt, input int unsigned rate);
    plan_row_t r;
    r.kind     = ROW_SAMPLE;
    r.reg_idx  = '0;
    r.reg_data = '0;
    r.smp      = '{sample_time: t, pressure: p};
    r.typed    = 1'b1;
    r.want     = '{rhythm_alarm: alarm, pressed: prs,
                   window_count: COUNT_W'(cnt), rate_centi: RATE_W'(rate)};
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // random press trains
  // ---------------------------------------------------------------------
  logic [TIME_W-1:0] gen_time;       // running clock of the train
  logic [TIME_W-1:0] gen_last;       // time of the train's last press
  bit                gen_want_press;

  // mostly alternating release / press with intervals near the good range,
  // the rest raw noise over the whole field range
  task automatic make_item(input int unsigned span, output sample_t s);
    logic [TIME_W-1:0] t;
    int unsigned       top;
    int unsigned       target;
    if ($urandom_range(99) < 10) begin
      s.sample_time = $urandom();
      s.pressure    = PRES_W'($urandom_range(0, 4095));
    end else if (gen_want_press) begin
      s.pressure = (cf_thr == '0) ? '0 : PRES_W'($urandom_range(0, cf_thr - 1));
      top = (cf_hi < cf_lo + span) ? cf_hi : cf_lo + span;
      if (cf_lo <= cf_hi && $urandom_range(99) < 70)
        target = $urandom_range(cf_lo, top);
      else
        target = $urandom_range(0, span);
      t = gen_last + target;
      if (t < gen_time)
        t = gen_time;
      gen_time       = t;
      gen_last       = t;
      s.sample_time  = t;
      gen_want_press = 1'b0;
    end else begin
      s.pressure     = PRES_W'($urandom_range(cf_thr, 4095));
      gen_time       = gen_time + $urandom_range(0, span / 2);
      s.sample_time  = gen_time;
      gen_want_press = 1'b1;
    end
  endtask

  // one random phase: drain, program all registers, then stream samples;
  // optionally a long result hold-off and a full sender pause midway
  task automatic run_phase(input int n, input logic [CFG_DATA_W-1:0] thr,
                           input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                           input logic [CFG_DATA_W-1:0] win, input int unsigned span,
                           input int s_pct, input int r_pct, input bit pressure_test);
    sample_t s;
    drain_readings();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_IVL_MIN, lo);
    write_reg(REG_IVL_MAX, hi);
    write_reg(REG_WINDOW, win);
    send_idle_pct <= s_pct;
    recv_idle_pct <= r_pct;
    @(posedge clk);
    for (int i = 0; i < n; i++) begin
      if (pressure_test && i == n / 3)
        hold_toggle <= ~hold_toggle;
      if (pressure_test && i == (2 * n) / 3)
        drain_readings();
      make_item(span, s);
      send_sample(s, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    samp_ch.valid       = 1'b0;
    samp_ch.sample_time = '0;
    samp_ch.pressure    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    res_ch.ready        = 1'b0;
    hold_toggle         = 1'b0;
    hold_seen           = 1'b0;
    hold_left           = 0;
    quiet_cycles        = 0;
    errors              = 0;
    send_idle_pct       = 23;
    recv_idle_pct       = 55;

    // predictor at its reset state
    cf_thr     = THRESHOLD_RST;
    cf_lo      = IVL_MIN_RST;
    cf_hi      = IVL_MAX_RST;
    cf_win     = WINDOW_RST;
    st_held    = 0;
    st_slot    = 0;
    st_latched = 1'b0;
    st_last    = '0;
    st_alarm   = 1'b0;

    // defaults: threshold 30, good interval 100..120 ms, window 5000 ms
    add_chk(32'd0, PRES_TOP, 0, 0, 0, 0);           // idle after reset
    add_chk(32'd0, 12'd0, 1, 1, 0, 0);              // press at time zero, never counted
    add_chk(32'd50, 12'd30, 1, 0, 0, 0);            // level equal to threshold rearms
    add_smp(32'd150, 12'd29);                       // interval 150, too slow
    add_smp(32'd200, 12'd29);                       // still held down, no new press
    add_smp(32'd210, PRES_TOP);
    add_smp(32'd260, 12'd0);                        // interval 110, good rhythm
    add_smp(32'd261, 12'd100);
    add_smp(32'd361, 12'd5);                        // interval 101, still good
    add_smp(32'd380, 12'd2000);
    add_smp(32'd300, 12'd1);                        // time steps back, future stamp counts
    add_smp(32'd5300, PRES_TOP);                    // window edge: age exactly 5000 counts
    // empty good range: every press alarms
    add_cfg(REG_IVL_MIN, 16'd200);
    add_cfg(REG_IVL_MAX, 16'd100);
    add_smp(32'd5400, 12'd0);
    add_smp(32'd5401, PRES_TOP);
    add_smp(32'd5550, 12'd0);
    // zero window: saturated rate once anything counts
    add_cfg(REG_WINDOW, 16'd0);
    add_smp(32'd5600, PRES_TOP);
    add_smp(32'd5700, 12'd0);
    // one-millisecond window overflows the rate
    add_cfg(REG_WINDOW, 16'd1);
    add_chk(32'd5701, PRES_TOP, 1, 0, 1, RATE_MAX);
    // upper data bits dropped: threshold 0, nothing is ever below it
    add_cfg(REG_THRESHOLD, 16'hF000);
    add_chk(32'd5800, 12'd0, 1, 0, 0, 0);
    add_cfg(REG_THRESHOLD, 16'h0FFF);
    add_cfg(REG_UNMAPPED_LO, 16'hFFFF);             // ignored
    add_cfg(REG_UNMAPPED_HI, 16'h5A5A);             // ignored
    add_cfg(REG_WINDOW, 16'hFFFF);
    add_cfg(REG_IVL_MIN, 16'd0);
    add_cfg(REG_IVL_MAX, 16'hFFFF);
    add_smp(32'd5900, 12'd4094);
    add_smp(32'd5901, PRES_TOP);                    // top level is never below
    add_smp(32'hFFFF_FFFF, PRES_TOP);
    add_smp(32'hFFFF_FFFF, 12'd0);                  // press at the last time value

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_readings();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_sample(plan[i].smp, plan[i].typed, plan[i].want);
      end
    end

    // random trains restart well below the last directed time
    gen_time       = 32'd6000;
    gen_last       = 32'd6000;
    gen_want_press = 1'b0;

    // defaults again, sender idles less than receiver
    run_phase(120, 16'd30, 16'd100, 16'd120, 16'd5000, 250, 23, 55, 1'b0);
    // other way round; empty good range, window of 1000 ms
    run_phase(100, {4'($urandom_range(0, 15)), 12'($urandom_range(1, 4095))},
              16'($urandom_range(5000, 65535)), 16'($urandom_range(0, 4999)),
              16'd1000, 3000, 55, 23, 1'b0);
    // no idling, random settings
    run_phase(100, {4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095))},
              16'($urandom_range(0, 400)), 16'($urandom_range(300, 900)),
              16'($urandom_range(1000, 65535)), 600, 0, 0, 1'b0);
    // widest window, dense presses: store wraps and the count can reach every stamp held;
    // long result hold-off and a full sender pause on the way
    run_phase(300, 16'h0FFF, 16'd0, 16'hFFFF, 16'hFFFF, 40, 0, 0, 1'b1);

    drain_readings();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("press_rate_monitor test passed");
    else
      $display("press_rate_monitor test failed");
    $finish;
  end

endmodule
